### hdl/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types and constants of the two-resource interval assigner.
// ----------------------------------------------------------------------------
package trs_pkg;

   localparam int TRS_MAX_INTERVALS = 16;
   localparam int TRS_TIME_WIDTH    = 16;

   typedef struct packed {
      logic [TRS_TIME_WIDTH-1:0] start_time;
      logic [TRS_TIME_WIDTH-1:0] end_time;
      logic                      last_interval;
   } trs_req_type;

   typedef struct packed {
      logic assignee;
      logic impossible;
      logic last_result;
   } trs_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_SEARCH_INIT,
      ST_CHECK,
      ST_RESULT,
      ST_IMPOSSIBLE
   } trs_state_type;

endpackage

### hdl/trs_store.sv
// ----------------------------------------------------------------------------
// trs_store
// Interval store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module trs_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 36,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/trs_ctrl.sv
// ----------------------------------------------------------------------------
// trs_ctrl
// Sorted insertion, mask search and result sequencing around the store.
// ----------------------------------------------------------------------------
module trs_ctrl import trs_pkg::*; #(
   parameter int MAX_INTERVALS = TRS_MAX_INTERVALS,
   parameter int AW            = 4,
   parameter int WIDTH         = 36
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  trs_req_type      req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output trs_rsp_type      rsp_data,
   output logic             wr_en,
   output logic [AW-1:0]    wr_addr,
   output logic [WIDTH-1:0] wr_data,
   output logic [AW-1:0]    rd_addr,
   input  logic [WIDTH-1:0] rd_data
);

   localparam int TW = TRS_TIME_WIDTH;
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam int MW = MAX_INTERVALS + 1;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_INTERVALS);
   localparam logic [MW-1:0] MASK_ONE  = MW'(1);

   trs_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, pos_ff, pos_in, idx_ff, idx_in;
   logic [MW-1:0] mask_ff, mask_in;
   logic [TW-1:0] start_ff, start_in, end_ff, end_in, end_a_ff, end_a_in, end_b_ff, end_b_in;
   logic          last_ff, last_in;
   logic [MAX_INTERVALS-1:0] asg_ff, asg_in;

   logic [TW-1:0] rd_start, rd_end, prev_end;
   logic [AW-1:0] rd_arr;
   logic          cur_bit, chk_ok, chk_last, insert_here, exhausted, store_full;
   logic [MW-1:0] mask_next;

   assign rd_start    = rd_data[2*TW+AW-1 -: TW];
   assign rd_end      = rd_data[TW+AW-1 -: TW];
   assign rd_arr      = rd_data[AW-1:0];
   assign cur_bit     = mask_ff[idx_ff[AW-1:0]];
   assign prev_end    = cur_bit ? end_b_ff : end_a_ff;
   assign chk_ok      = prev_end <= rd_start;
   assign chk_last    = (idx_ff + CW'(1)) == count_ff;
   assign mask_next   = mask_ff + MASK_ONE;
   assign exhausted   = mask_next == (MASK_ONE << count_ff);
   assign insert_here = (pos_ff == '0) || (rd_start <= start_ff);
   assign store_full  = count_ff >= MAX_COUNT;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!store_full) begin
                  state_in = ST_INSERT;
               end else if (req_data.last_interval) begin
                  state_in = ST_SEARCH_INIT;
               end
            end
         end
         ST_INSERT: begin
            if (insert_here) begin
               state_in = last_ff ? ST_SEARCH_INIT : ST_IDLE;
            end
         end
         ST_SEARCH_INIT: state_in = ST_CHECK;
         ST_CHECK: begin
            if (chk_ok && chk_last) begin
               state_in = ST_RESULT;
            end else if (!chk_ok && exhausted) begin
               state_in = ST_IMPOSSIBLE;
            end
         end
         ST_RESULT: begin
            if (rsp_ready && chk_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IMPOSSIBLE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_ready            = state_ff == ST_IDLE;
      rsp_valid            = (state_ff == ST_RESULT) || (state_ff == ST_IMPOSSIBLE);
      rsp_data.impossible  = state_ff == ST_IMPOSSIBLE;
      rsp_data.assignee    = (state_ff == ST_RESULT) ? asg_ff[idx_ff[AW-1:0]] : 1'b0;
      rsp_data.last_result = (state_ff == ST_IMPOSSIBLE) || chk_last;
   end

   // Datapath and store accesses.
   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      mask_in  = mask_ff;
      start_in = start_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      end_a_in = end_a_ff;
      end_b_in = end_b_ff;
      asg_in   = asg_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      rd_addr  = '0;
      case (state_ff)
         ST_IDLE: begin
            start_in = req_data.start_time;
            end_in   = req_data.end_time;
            last_in  = req_data.last_interval;
            pos_in   = count_ff;
            rd_addr  = AW'(count_ff - CW'(1));
         end
         ST_INSERT: begin
            // Entries with a later start move up one place; equal starts stay below.
            wr_en   = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            if (insert_here) begin
               wr_data  = {start_ff, end_ff, count_ff[AW-1:0]};
               count_in = count_ff + CW'(1);
            end else begin
               wr_data = rd_data;
               pos_in  = pos_ff - CW'(1);
               rd_addr = AW'(pos_ff - CW'(2));
            end
         end
         ST_SEARCH_INIT: begin
            mask_in  = '0;
            idx_in   = '0;
            end_a_in = '0;
            end_b_in = '0;
         end
         ST_CHECK: begin
            if (chk_ok) begin
               asg_in[rd_arr] = cur_bit;
               if (cur_bit) begin
                  end_b_in = rd_end;
               end else begin
                  end_a_in = rd_end;
               end
               if (chk_last) begin
                  idx_in = '0;
               end else begin
                  idx_in  = idx_ff + CW'(1);
                  rd_addr = AW'(idx_ff + CW'(1));
               end
            end else begin
               idx_in   = '0;
               end_a_in = '0;
               end_b_in = '0;
               if (exhausted) begin
                  mask_in = mask_next;
               end else begin
                  mask_in = mask_next;
               end
            end
         end
         ST_RESULT: begin
            if (rsp_ready) begin
               if (chk_last) begin
                  count_in = '0;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end
         end
         ST_IMPOSSIBLE: begin
            if (rsp_ready) begin
               count_in = '0;
            end
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         mask_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         mask_ff  <= mask_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      last_ff  <= last_in;
      end_a_ff <= end_a_in;
      end_b_ff <= end_b_in;
      asg_ff   <= asg_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("interval count beyond store depth");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("input taken while a result is pending");

   a_impossible_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.impossible) |-> rsp_data.last_result)
      else $error("impossible beat without last flag");

   a_set_closed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_result) |=> (count_ff == '0))
      else $error("set not cleared after final result");

endmodule

### hdl/two_resource_interval_assigner_unit.sv
// ----------------------------------------------------------------------------
// two_resource_interval_assigner_unit
// Insert: an interval is stored once the entries that start later have moved up,
//   one store entry shifted per cycle through the single write port.
// Search: one interval checked per cycle; each tried mask restarts at the first
//   sorted interval; results then leave one beat a cycle while rsp_ready is high.
// Reset: synchronous, clears control state; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module two_resource_interval_assigner_unit import trs_pkg::*; #(
   parameter int MAX_INTERVALS = TRS_MAX_INTERVALS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  trs_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output trs_rsp_type rsp_data
);

   localparam int AW    = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int WIDTH = 2 * TRS_TIME_WIDTH + AW;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [WIDTH-1:0] wr_data, rd_data;

   trs_store #(
      .DEPTH (MAX_INTERVALS),
      .WIDTH (WIDTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   trs_ctrl #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .AW            (AW),
      .WIDTH         (WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

endmodule

### test/tb_two_resource_interval_assigner_unit.sv
// ----------------------------------------------------------------------------
// tb_two_resource_interval_assigner_unit
// Self-checking bench: sends sets of intervals and compares every returned
// assignment with a behavioural prediction of the two-resource search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_resource_interval_assigner_unit;
   import trs_pkg::*;

   localparam int CYCLE_LIMIT = 10000000;

   // Keeps the pending interval set and the assignments still owed by the block.
   class assignment_scoreboard;
      logic [TRS_TIME_WIDTH-1:0] starts[TRS_MAX_INTERVALS];
      logic [TRS_TIME_WIDTH-1:0] ends[TRS_MAX_INTERVALS];
      int unsigned               arrival[TRS_MAX_INTERVALS];
      int unsigned               count;
      trs_rsp_type               owed[$];
      int unsigned               mismatches;
      int unsigned               beats_checked;
      int unsigned               impossible_sets;
      int unsigned               sets_closed;

      function void note_interval(trs_req_type beat);
         int unsigned pos;
         bit          side[TRS_MAX_INTERVALS];
         bit          found;
         logic [TRS_TIME_WIDTH-1:0] end_a, end_b;
         trs_rsp_type r;
         if (count < TRS_MAX_INTERVALS) begin
            pos = count;
            while (pos > 0 && starts[pos-1] > beat.start_time) begin
               starts[pos]  = starts[pos-1];
               ends[pos]    = ends[pos-1];
               arrival[pos] = arrival[pos-1];
               pos--;
            end
            starts[pos]  = beat.start_time;
            ends[pos]    = beat.end_time;
            arrival[pos] = count;
            count++;
         end
         if (!beat.last_interval) return;
         found = 0;
         for (int unsigned m = 0; m < (1 << count) && !found; m++) begin
            end_a = '0;
            end_b = '0;
            found = 1;
            for (int unsigned j = 0; j < count && found; j++) begin
               if (m[j]) begin
                  if (end_b > starts[j]) found = 0;
                  end_b = ends[j];
               end else begin
                  if (end_a > starts[j]) found = 0;
                  end_a = ends[j];
               end
               side[arrival[j]] = m[j];
            end
         end
         sets_closed++;
         if (!found) begin
            impossible_sets++;
            r.assignee = 1'b0;
            r.impossible = 1'b1;
            r.last_result = 1'b1;
            owed = {owed, r};
         end else begin
            for (int unsigned k = 0; k < count; k++) begin
               r.assignee = side[k];
               r.impossible = 1'b0;
               r.last_result = (k + 1 == count);
               owed = {owed, r};
            end
         end
         count = 0;
      endfunction

      function void check_result(trs_rsp_type got);
         trs_rsp_type want;
         beats_checked++;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: %b/%b/%b",
                        got.assignee, got.impossible, got.last_result);
            return;
         end
         want = owed.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: assignee %b/%b impossible %b/%b last %b/%b (exp/got)",
                        beats_checked, want.assignee, got.assignee, want.impossible,
                        got.impossible, want.last_result, got.last_result);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   trs_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   trs_rsp_type rsp_data;

   assignment_scoreboard sb;
   int unsigned intervals_sent;
   int unsigned burst_left;
   int unsigned hold_off;
   int unsigned cycles;

   two_resource_interval_assigner_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stall pattern in windows, with an occasional long hold-off.
   initial begin
      int unsigned window;
      int unsigned mode;
      window = 0;
      mode = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (window == 0) begin
            window = $urandom_range(20, 120);
            mode = $urandom_range(0, 2);
         end
         window--;
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else if (mode == 0) begin
            rsp_ready <= 1'b1;
         end else if (mode == 1) begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end else begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still owed", cycles, sb.owed.size());
            $display("[two_resource_interval_assigner_unit] ERROR");
            $finish;
         end
      end
   end

   // One interval beat, sent in bursts with random gaps between them.
   task automatic send_interval(input logic [15:0] s, input logic [15:0] e, input bit last);
      trs_req_type beat;
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      beat.start_time = s;
      beat.end_time = e;
      beat.last_interval = last;
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_interval(beat);
      intervals_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
   endtask

   // A set of n intervals; span picks how crowded the time axis is.
   task automatic send_random_set(input int unsigned n, input int unsigned span);
      logic [15:0] s, e;
      for (int unsigned i = 0; i < n; i++) begin
         if (span == 0) begin
            s = 16'($urandom);
            e = 16'($urandom);
         end else begin
            s = 16'($urandom_range(0, span));
            e = 16'(s + $urandom_range(0, span / 2));
            if ($urandom_range(0, 15) == 0) e = 16'(s - $urandom_range(1, 5));
         end
         send_interval(s, e, i + 1 == n);
      end
   endtask

   initial begin
      int unsigned n;
      sb = new();
      intervals_sent = 0;
      burst_left = 0;
      hold_off = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single, touching, equal starts, no solution, reversed, extremes.
      send_interval(16'd0, 16'd0, 1'b1);
      send_interval(16'd0, 16'd10, 1'b0);
      send_interval(16'd10, 16'd20, 1'b1);
      send_interval(16'd5, 16'd9, 1'b0);
      send_interval(16'd5, 16'd9, 1'b1);
      send_interval(16'd1, 16'd5, 1'b0);
      send_interval(16'd2, 16'd6, 1'b0);
      send_interval(16'd3, 16'd7, 1'b1);
      send_interval(16'd100, 16'd50, 1'b0);
      send_interval(16'd60, 16'd70, 1'b1);
      send_interval(16'hFFFF, 16'hFFFF, 1'b0);
      send_interval(16'd0, 16'hFFFF, 1'b0);
      send_interval(16'hFFFF, 16'd0, 1'b1);
      wait_drained();

      // Receiver holds off while the sender keeps offering.
      hold_off = 400;
      send_random_set(6, 40);
      send_random_set(5, 40);
      send_random_set(4, 40);
      wait_drained();

      // Overfull set: the extra intervals are dropped, the last still closes it.
      for (int unsigned i = 0; i < 18; i++)
         send_interval(i < 16 ? 16'(i * 100) : 16'($urandom),
                       i < 16 ? 16'(i * 100 + 100) : 16'($urandom),
                       i == 17);
      wait_drained();
      // Full set with two interleaved chains.
      for (int unsigned i = 0; i < 16; i++)
         send_interval(16'(i * 50), 16'(i * 50 + 90), i == 15);

      while (intervals_sent < 470) begin
         if ($urandom_range(0, 19) == 0) n = $urandom_range(7, 10);
         else n = $urandom_range(1, 6);
         send_random_set(n, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(8, 60));
         if ($urandom_range(0, 29) == 0) wait_drained();
         if ($urandom_range(0, 59) == 0) hold_off = $urandom_range(150, 300);
      end

      wait_drained();
      repeat (200) @(posedge clock);
      $display("sent %0d intervals in %0d sets (%0d without a solution), %0d beats checked",
               intervals_sent, sb.sets_closed, sb.impossible_sets, sb.beats_checked);
      $display("%0d mismatches, %0d beats never returned", sb.mismatches, sb.owed.size());
      if (sb.mismatches == 0 && sb.owed.size() == 0)
         $display("[two_resource_interval_assigner_unit] OK");
      else
         $display("[two_resource_interval_assigner_unit] ERROR");
      $finish;
   end

endmodule
